/* hdl/ldcs_pkg.sv */
// Shared types, opcodes, state codes and the 5x8 font table of the LCD draw sequencer.
package ldcs_pkg;

  localparam int GLYPH_COUNT_DEF = 95;
  localparam int GLYPH_WIDTH_DEF = 5;
  localparam int FIRST_CODE_DEF  = 32;

  localparam logic [1:0] REQ_FILL  = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_CHAR  = 2'd2;
  localparam logic [1:0] REQ_PULL  = 2'd3;

  localparam logic [1:0] KIND_IDLE  = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_PIXEL = 2'd2;
  localparam logic [1:0] KIND_CHAR  = 2'd3;

  localparam logic [2:0] HS_COLSET   = 3'd0;
  localparam logic [2:0] HS_XLOW     = 3'd1;
  localparam logic [2:0] HS_XHIGH    = 3'd2;
  localparam logic [2:0] HS_PAGESET  = 3'd3;
  localparam logic [2:0] HS_YLOW     = 3'd4;
  localparam logic [2:0] HS_YHIGH    = 3'd5;
  localparam logic [2:0] HS_MEMWRITE = 3'd6;
  localparam logic [2:0] HS_PIXELS   = 3'd7;

  localparam logic [7:0] OP_COLSET   = 8'h2A;
  localparam logic [7:0] OP_PAGESET  = 8'h2B;
  localparam logic [7:0] OP_MEMWRITE = 8'h2C;

  localparam int FONT_AW  = 11;
  localparam int ROM_SIZE = 475;
  localparam int ROM_IW   = 9;

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } ldcs_word_t;

  localparam logic [7:0] FONT_ROM [ROM_SIZE] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h06,8'h5F,8'h06,8'h00,
    8'h07,8'h03,8'h00,8'h07,8'h03, 8'h24,8'h7E,8'h24,8'h7E,8'h24,
    8'h24,8'h2B,8'h6A,8'h12,8'h00, 8'h63,8'h13,8'h08,8'h64,8'h63,
    8'h36,8'h49,8'h56,8'h20,8'h50, 8'h00,8'h07,8'h03,8'h00,8'h00,
    8'h00,8'h3E,8'h41,8'h00,8'h00, 8'h00,8'h41,8'h3E,8'h00,8'h00,
    8'h08,8'h3E,8'h1C,8'h3E,8'h08, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'hE0,8'h60,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
    8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h62,8'h51,8'h49,8'h49,8'h46, 8'h22,8'h49,8'h49,8'h49,8'h36,
    8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h2F,8'h49,8'h49,8'h49,8'h31,
    8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
    8'h00,8'h6C,8'h6C,8'h00,8'h00, 8'h00,8'hEC,8'h6C,8'h00,8'h00,
    8'h08,8'h14,8'h22,8'h41,8'h00, 8'h24,8'h24,8'h24,8'h24,8'h24,
    8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h59,8'h09,8'h06,
    8'h3E,8'h41,8'h5D,8'h55,8'h1E, 8'h7E,8'h09,8'h09,8'h09,8'h7E,
    8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h49,8'h49,8'h49,8'h41,
    8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h3E,8'h41,8'h49,8'h49,8'h7A,
    8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h30,8'h40,8'h40,8'h40,8'h3F, 8'h7F,8'h08,8'h14,8'h22,8'h41,
    8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h04,8'h02,8'h7F,
    8'h7F,8'h02,8'h04,8'h08,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
    8'h7F,8'h09,8'h09,8'h19,8'h66, 8'h26,8'h49,8'h49,8'h49,8'h32,
    8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h3C,8'h40,8'h3F,
    8'h63,8'h14,8'h08,8'h14,8'h63, 8'h07,8'h08,8'h70,8'h08,8'h07,
    8'h71,8'h49,8'h45,8'h43,8'h00, 8'h00,8'h7F,8'h41,8'h41,8'h00,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7F,8'h00,
    8'h04,8'h02,8'h01,8'h02,8'h04, 8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h20,8'h40,8'h80,8'h40,8'h20, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h44,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h28,
    8'h38,8'h44,8'h44,8'h44,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18,
    8'h08,8'h7E,8'h09,8'h09,8'h00, 8'h18,8'hA4,8'hA4,8'hA4,8'h7C,
    8'h7F,8'h04,8'h04,8'h78,8'h00, 8'h00,8'h00,8'h7D,8'h00,8'h00,
    8'h40,8'h80,8'h84,8'h7D,8'h00, 8'h7F,8'h10,8'h28,8'h44,8'h00,
    8'h00,8'h00,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,
    8'h7C,8'h04,8'h04,8'h78,8'h00, 8'h38,8'h44,8'h44,8'h44,8'h38,
    8'hFC,8'h44,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'hFC,
    8'h44,8'h78,8'h44,8'h04,8'h08, 8'h08,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3E,8'h44,8'h24,8'h00, 8'h3C,8'h40,8'h20,8'h7C,8'h00,
    8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h60,8'h30,8'h60,8'h3C,
    8'h6C,8'h10,8'h10,8'h6C,8'h00, 8'h9C,8'hA0,8'h60,8'h3C,8'h00,
    8'h64,8'h54,8'h54,8'h4C,8'h00, 8'h33,8'h66,8'hCC,8'h66,8'h33,
    8'h00,8'h00,8'h7F,8'h00,8'h00, 8'hCC,8'h66,8'h33,8'h66,8'hCC,
    8'h02,8'h01,8'h02,8'h01,8'h00
  };

endpackage

/* hdl/lcd_draw_command_sequencer.sv */
// Top level of the LCD draw command sequencer.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | req_type, colors, corners, char_code
//   out     | output    | out_valid_o/out_ready_i | is_data, out_value, last_word
//
// One transaction per cycle unless stalled: each input is handled in the cycle it
// is accepted, and a pull's word sits in the result register on the next cycle.
// Input is taken whenever the result register is empty or being drained.
// Font bytes come from a registered ROM read addressed by next-state glyph and column.
// Reset clears the sequencer to idle and empties the result register.
module lcd_draw_command_sequencer
  import ldcs_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF,
  parameter int FIRST_CODE  = FIRST_CODE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] fore_color_i,
  input  logic [7:0] back_color_i,
  input  logic [7:0] x_first_i,
  input  logic [7:0] y_first_i,
  input  logic [7:0] x_second_i,
  input  logic [7:0] y_second_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_data_o,
  output logic [7:0] out_value_o,
  output logic       last_word_o
);

  logic               fire;
  logic               word_valid;
  ldcs_word_t         word, out_word;
  logic [FONT_AW-1:0] font_addr;
  logic [7:0]         font_data;

  assign fire = in_valid_i && in_ready_o;

  ldcs_seq_core #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .FIRST_CODE  (FIRST_CODE)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .req_type_i   (req_type_i),
    .fore_color_i (fore_color_i),
    .back_color_i (back_color_i),
    .x_first_i    (x_first_i),
    .y_first_i    (y_first_i),
    .x_second_i   (x_second_i),
    .y_second_i   (y_second_i),
    .char_code_i  (char_code_i),
    .font_data_i  (font_data),
    .font_addr_o  (font_addr),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  ldcs_font_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (font_addr),
    .data_o (font_data)
  );

  ldcs_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (word_valid),
    .word_i  (word),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .word_o  (out_word)
  );

  assign is_data_o   = out_word.is_data;
  assign out_value_o = out_word.value;
  assign last_word_o = out_word.last;

endmodule

/* hdl/ldcs_font_rom.sv */
// Font ROM with registered read; an address past the table reads as zero.
module ldcs_font_rom
  import ldcs_pkg::*;
(
  input  logic               clk_i,
  input  logic [FONT_AW-1:0] addr_i,
  output logic [7:0]         data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (addr_i < FONT_AW'(ROM_SIZE)) begin
      data_q <= FONT_ROM[addr_i[ROM_IW-1:0]];
    end else begin
      data_q <= '0;
    end
  end

  assign data_o = data_q;

endmodule

/* hdl/ldcs_seq_core.sv */
// Sequencer state: command latch, header stepping, pixel and glyph counters, word generation.
module ldcs_seq_core
  import ldcs_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF,
  parameter int FIRST_CODE  = FIRST_CODE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         fore_color_i,
  input  logic [7:0]         back_color_i,
  input  logic [7:0]         x_first_i,
  input  logic [7:0]         y_first_i,
  input  logic [7:0]         x_second_i,
  input  logic [7:0]         y_second_i,
  input  logic [7:0]         char_code_i,
  input  logic [7:0]         font_data_i,
  output logic [FONT_AW-1:0] font_addr_o,
  output logic               word_valid_o,
  output ldcs_word_t         word_o
);

  localparam int CW = $clog2(GLYPH_WIDTH + 1);

  logic [1:0]    active_q, active_d;
  logic [2:0]    step_q, step_d;
  logic [16:0]   left_q, left_d;
  logic [CW-1:0] col_q, col_d;
  logic [2:0]    row_q, row_d;
  logic [7:0]    xlo_q, xlo_d, xhi_q, xhi_d, ylo_q, ylo_d, yhi_q, yhi_d;
  logic [7:0]    fore_q, fore_d, back_q, back_d;
  logic [6:0]    glyph_q, glyph_d;
  logic          blank_q, blank_d;

  logic [7:0]  col_byte;
  logic        pix_on;
  logic [7:0]  xmin, xmax, ymin, ymax;
  logic [16:0] area;
  logic [8:0]  code_ext, code_off;
  logic        code_hit;
  logic [7:0]  xlo_next;

  assign xmin     = (x_first_i <= x_second_i) ? x_first_i : x_second_i;
  assign xmax     = (x_first_i <= x_second_i) ? x_second_i : x_first_i;
  assign ymin     = (y_first_i <= y_second_i) ? y_first_i : y_second_i;
  assign ymax     = (y_first_i <= y_second_i) ? y_second_i : y_first_i;
  assign area     = ({1'b0, xmax} - {1'b0, xmin} + 9'd1) * ({1'b0, ymax} - {1'b0, ymin} + 9'd1);
  assign code_ext = {1'b0, char_code_i};
  assign code_off = code_ext - 9'(FIRST_CODE);
  assign code_hit = (code_ext >= 9'(FIRST_CODE)) && (code_off < 9'(GLYPH_COUNT));
  assign xlo_next = xlo_q + 8'd1;

  assign col_byte = (blank_q || (col_q >= CW'(GLYPH_WIDTH))) ? 8'd0 : font_data_i;
  assign pix_on   = col_byte[row_q];

  always_comb begin
    active_d = active_q;
    step_d   = step_q;
    left_d   = left_q;
    col_d    = col_q;
    row_d    = row_q;
    xlo_d    = xlo_q;
    xhi_d    = xhi_q;
    ylo_d    = ylo_q;
    yhi_d    = yhi_q;
    fore_d   = fore_q;
    back_d   = back_q;
    glyph_d  = glyph_q;
    blank_d  = blank_q;
    word_valid_o   = 1'b0;
    word_o.is_data = 1'b1;
    word_o.value   = 8'd0;
    word_o.last    = 1'b0;

    if (fire_i && (req_type_i != REQ_PULL) && (active_q == KIND_IDLE)) begin
      fore_d   = fore_color_i;
      back_d   = back_color_i;
      step_d   = HS_COLSET;
      col_d    = '0;
      row_d    = '0;
      active_d = req_type_i + 2'd1;
      case (req_type_i)
        REQ_FILL: begin
          xlo_d  = xmin;
          xhi_d  = xmax;
          ylo_d  = ymin;
          yhi_d  = ymax;
          left_d = area;
        end
        REQ_PIXEL: begin
          xlo_d  = x_first_i;
          xhi_d  = x_first_i + 8'd1;
          ylo_d  = y_first_i;
          yhi_d  = y_first_i + 8'd1;
          left_d = 17'd1;
        end
        default: begin
          xlo_d   = x_first_i;
          xhi_d   = x_first_i;
          ylo_d   = y_first_i;
          yhi_d   = y_first_i + 8'd7;
          left_d  = '0;
          glyph_d = code_hit ? code_off[6:0] : 7'd0;
          blank_d = !code_hit;
        end
      endcase
    end else if (fire_i && (req_type_i == REQ_PULL) && (active_q != KIND_IDLE)) begin
      word_valid_o = 1'b1;
      if (step_q != HS_PIXELS) begin
        step_d = step_q + 3'd1;
        case (step_q)
          HS_COLSET: begin
            word_o.is_data = 1'b0;
            word_o.value   = OP_COLSET;
          end
          HS_XLOW:  word_o.value = xlo_q;
          HS_XHIGH: word_o.value = xhi_q;
          HS_PAGESET: begin
            word_o.is_data = 1'b0;
            word_o.value   = OP_PAGESET;
          end
          HS_YLOW:  word_o.value = ylo_q;
          HS_YHIGH: word_o.value = yhi_q;
          default: begin
            word_o.is_data = 1'b0;
            word_o.value   = OP_MEMWRITE;
          end
        endcase
      end else if (active_q == KIND_CHAR) begin
        word_o.value = ~(pix_on ? fore_q : back_q);
        if (row_q == 3'd7) begin
          if (col_q >= CW'(GLYPH_WIDTH)) begin
            word_o.last = 1'b1;
            active_d    = KIND_IDLE;
          end else begin
            col_d  = col_q + CW'(1);
            row_d  = '0;
            step_d = HS_COLSET;
            xlo_d  = xlo_next;
            xhi_d  = xlo_next;
          end
        end else begin
          row_d = row_q + 3'd1;
        end
      end else begin
        word_o.value = ~fore_q;
        left_d = (left_q != '0) ? (left_q - 17'd1) : left_q;
        if (left_d == '0) begin
          word_o.last = 1'b1;
          active_d    = KIND_IDLE;
        end
      end
    end
  end

  assign font_addr_o = FONT_AW'(glyph_d) * FONT_AW'(GLYPH_WIDTH) + FONT_AW'(col_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= KIND_IDLE;
      step_q   <= HS_COLSET;
      left_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
      xlo_q    <= '0;
      xhi_q    <= '0;
      ylo_q    <= '0;
      yhi_q    <= '0;
      fore_q   <= '0;
      back_q   <= '0;
      glyph_q  <= '0;
      blank_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      step_q   <= step_d;
      left_q   <= left_d;
      col_q    <= col_d;
      row_q    <= row_d;
      xlo_q    <= xlo_d;
      xhi_q    <= xhi_d;
      ylo_q    <= ylo_d;
      yhi_q    <= yhi_d;
      fore_q   <= fore_d;
      back_q   <= back_d;
      glyph_q  <= glyph_d;
      blank_q  <= blank_d;
    end
  end

`ifndef SYNTH
  a_last_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid_o && word_o.last) |=> (active_q == KIND_IDLE))
    else $error("sequence did not end after last word");

  a_busy_cmd_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (req_type_i != REQ_PULL) && (active_q != KIND_IDLE))
      |=> ((active_q == $past(active_q)) && (step_q == $past(step_q))))
    else $error("command accepted while a sequence was pending");

  a_cmd_word_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid_o && !word_o.is_data) |=> (step_q != HS_COLSET) || (active_q == KIND_IDLE)
      || ($past(step_q) == HS_MEMWRITE) || ($past(step_q) == HS_PAGESET)
      || ($past(step_q) == HS_COLSET))
    else $error("command word issued outside the header");
`endif

endmodule

/* hdl/ldcs_out_reg.sv */
// Result register between the sequencer and the word consumer.
module ldcs_out_reg
  import ldcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  ldcs_word_t word_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output ldcs_word_t word_o
);

  logic       valid_q, valid_d;
  ldcs_word_t word_q;

  assign room_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || ready_i))
    else $error("pending transaction overwritten");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (valid_q && (word_q == $past(word_i))))
    else $error("loaded word not presented");

  a_drop_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && ready_i && !load_i) |=> !valid_q)
    else $error("taken transaction still presented");
`endif

endmodule

/* test/lcd_draw_command_sequencer_tb.sv */
// Testbench for the LCD draw command sequencer: directed and random drawing traffic.
`timescale 1ns / 100ps

module lcd_draw_command_sequencer_tb
  import ldcs_pkg::*;
();

  localparam int RANDOM_ITEMS = 250;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 2000;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] fore;
    logic [7:0] back;
    logic [7:0] xa;
    logic [7:0] ya;
    logic [7:0] xb;
    logic [7:0] yb;
    logic [7:0] code;
  } draw_req_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] req_type_i;
  logic [7:0] fore_color_i;
  logic [7:0] back_color_i;
  logic [7:0] x_first_i;
  logic [7:0] y_first_i;
  logic [7:0] x_second_i;
  logic [7:0] y_second_i;
  logic [7:0] char_code_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       is_data_o;
  logic [7:0] out_value_o;
  logic       last_word_o;

  logic [1:0]  seq_kind   = KIND_IDLE;
  logic [2:0]  hdr_step   = HS_COLSET;
  logic [16:0] px_left    = '0;
  logic [2:0]  col_idx    = '0;
  logic [2:0]  row_idx    = '0;
  logic [7:0]  box_xl     = '0;
  logic [7:0]  box_xh     = '0;
  logic [7:0]  box_yl     = '0;
  logic [7:0]  box_yh     = '0;
  logic [7:0]  fg_lat     = '0;
  logic [7:0]  bg_lat     = '0;
  logic [6:0]  glyph_sel  = '0;
  logic        glyph_none = 1'b0;

  ldcs_word_t pending_words[$];
  int errors     = 0;
  int items_done = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req   = 1'b0;

  lcd_draw_command_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .fore_color_i(fore_color_i),
    .back_color_i(back_color_i),
    .x_first_i   (x_first_i),
    .y_first_i   (y_first_i),
    .x_second_i  (x_second_i),
    .y_second_i  (y_second_i),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_data_o   (is_data_o),
    .out_value_o (out_value_o),
    .last_word_o (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] font_column();
    int addr;
    if (glyph_none || col_idx >= GLYPH_WIDTH_DEF) return 8'h00;
    addr = glyph_sel * GLYPH_WIDTH_DEF + col_idx;
    if (addr >= ROM_SIZE) return 8'h00;
    return FONT_ROM[addr];
  endfunction

  function automatic void start_sequence(draw_req_t r);
    fg_lat   = r.fore;
    bg_lat   = r.back;
    hdr_step = HS_COLSET;
    col_idx  = '0;
    row_idx  = '0;
    case (r.req)
      REQ_FILL: begin
        seq_kind = KIND_FILL;
        box_xl   = (r.xa <= r.xb) ? r.xa : r.xb;
        box_xh   = (r.xa <= r.xb) ? r.xb : r.xa;
        box_yl   = (r.ya <= r.yb) ? r.ya : r.yb;
        box_yh   = (r.ya <= r.yb) ? r.yb : r.ya;
        px_left  = 17'((int'(box_xh) - int'(box_xl) + 1) * (int'(box_yh) - int'(box_yl) + 1));
      end
      REQ_PIXEL: begin
        seq_kind = KIND_PIXEL;
        box_xl   = r.xa;
        box_xh   = r.xa + 8'd1;
        box_yl   = r.ya;
        box_yh   = r.ya + 8'd1;
        px_left  = 17'd1;
      end
      default: begin
        seq_kind = KIND_CHAR;
        box_xl   = r.xa;
        box_xh   = r.xa;
        box_yl   = r.ya;
        box_yh   = r.ya + 8'd7;
        px_left  = '0;
        if (r.code >= FIRST_CODE_DEF && r.code < FIRST_CODE_DEF + GLYPH_COUNT_DEF) begin
          glyph_sel  = 7'(r.code - FIRST_CODE_DEF);
          glyph_none = 1'b0;
        end else begin
          glyph_sel  = '0;
          glyph_none = 1'b1;
        end
      end
    endcase
  endfunction

  // Returns 1 when the transaction changes the sequencer, 0 when it is dropped.
  function automatic bit draw_engine_step(draw_req_t r);
    ldcs_word_t w;
    logic [7:0] colbits;
    if (r.req != REQ_PULL) begin
      if (seq_kind != KIND_IDLE) return 1'b0;
      start_sequence(r);
      return 1'b1;
    end
    if (seq_kind == KIND_IDLE) return 1'b0;
    w.is_data = 1'b1;
    w.value   = 8'h00;
    w.last    = 1'b0;
    if (hdr_step != HS_PIXELS) begin
      case (hdr_step)
        HS_COLSET: begin
          w.is_data = 1'b0;
          w.value   = OP_COLSET;
        end
        HS_XLOW:  w.value = box_xl;
        HS_XHIGH: w.value = box_xh;
        HS_PAGESET: begin
          w.is_data = 1'b0;
          w.value   = OP_PAGESET;
        end
        HS_YLOW:  w.value = box_yl;
        HS_YHIGH: w.value = box_yh;
        default: begin
          w.is_data = 1'b0;
          w.value   = OP_MEMWRITE;
        end
      endcase
      hdr_step = hdr_step + 3'd1;
    end else if (seq_kind == KIND_CHAR) begin
      colbits = font_column();
      w.value = colbits[row_idx] ? ~fg_lat : ~bg_lat;
      if (row_idx == 3'd7) begin
        if (col_idx >= GLYPH_WIDTH_DEF) begin
          w.last   = 1'b1;
          seq_kind = KIND_IDLE;
        end else begin
          col_idx  = col_idx + 3'd1;
          row_idx  = '0;
          hdr_step = HS_COLSET;
          box_xl   = box_xl + 8'd1;
          box_xh   = box_xl;
        end
      end else begin
        row_idx = row_idx + 3'd1;
      end
    end else begin
      w.value = ~fg_lat;
      if (px_left != 0) px_left = px_left - 17'd1;
      if (px_left == 0) begin
        w.last   = 1'b1;
        seq_kind = KIND_IDLE;
      end
    end
    pending_words.push_back(w);
    return 1'b1;
  endfunction

  function automatic draw_req_t make_req(logic [1:0] kind, logic [7:0] fore, logic [7:0] back,
                                         logic [7:0] xa, logic [7:0] ya, logic [7:0] xb,
                                         logic [7:0] yb, logic [7:0] code);
    draw_req_t r;
    r.req  = kind;
    r.fore = fore;
    r.back = back;
    r.xa   = xa;
    r.ya   = ya;
    r.xb   = xb;
    r.yb   = yb;
    r.code = code;
    return r;
  endfunction

  function automatic draw_req_t noise_req(logic [1:0] kind);
    return make_req(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic logic [7:0] near_coord(logic [7:0] v);
    int lo;
    int hi;
    lo = (v > 4) ? int'(v) - 4 : 0;
    hi = (v < 251) ? int'(v) + 4 : 255;
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic draw_req_t random_command();
    draw_req_t r;
    int pick;
    r    = noise_req(REQ_FILL);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 1) r.yb = r.ya;
        else r.xb = r.xa;
      end else begin
        r.xb = near_coord(r.xa);
        r.yb = near_coord(r.ya);
      end
    end else if (pick < 60) begin
      r.req = REQ_PIXEL;
    end else begin
      r.req = REQ_CHAR;
      if ($urandom_range(0, 3) != 0)
        r.code = 8'($urandom_range(FIRST_CODE_DEF + GLYPH_COUNT_DEF - 1, FIRST_CODE_DEF));
    end
    return r;
  endfunction

  task automatic idle_sender();
    int n;
    n = tx_idle_en ? gap_cycles() : 0;
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_draw_req(draw_req_t r);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    req_type_i   <= r.req;
    fore_color_i <= r.fore;
    back_color_i <= r.back;
    x_first_i    <= r.xa;
    y_first_i    <= r.ya;
    x_second_i   <= r.xb;
    y_second_i   <= r.yb;
    char_code_i  <= r.code;
    do @(posedge clk_i); while (!in_ready_o);
    if (draw_engine_step(r)) items_done++;
    idle_sender();
  endtask

  task automatic run_sequence(draw_req_t cmd);
    send_draw_req(cmd);
    while (seq_kind != KIND_IDLE) send_draw_req(noise_req(REQ_PULL));
  endtask

  task automatic test_idle_pull();
    repeat (3) send_draw_req(noise_req(REQ_PULL));
  endtask

  task automatic test_fill_rect();
    run_sequence(make_req(REQ_FILL, 8'h00, 8'hFF, 8'd5, 8'd9, 8'd2, 8'd3, 8'h00));
    run_sequence(make_req(REQ_FILL, 8'hFF, 8'h00, 8'd255, 8'd255, 8'd255, 8'd255, 8'hFF));
    run_sequence(make_req(REQ_FILL, 8'h3C, 8'hC3, 8'd0, 8'd255, 8'd3, 8'd250, 8'h41));
  endtask

  task automatic test_put_pixel();
    run_sequence(make_req(REQ_PIXEL, 8'h00, 8'hFF, 8'd0, 8'd0, 8'd9, 8'd9, 8'h20));
    run_sequence(make_req(REQ_PIXEL, 8'hFF, 8'h00, 8'd255, 8'd255, 8'd0, 8'd0, 8'h7E));
    run_sequence(make_req(REQ_PIXEL, 8'h5A, 8'hA5, 8'd128, 8'd127, 8'd1, 8'd2, 8'h00));
  endtask

  task automatic test_draw_char();
    run_sequence(make_req(REQ_CHAR, 8'hFF, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd32));
    run_sequence(make_req(REQ_CHAR, 8'h00, 8'hFF, 8'd252, 8'd250, 8'd0, 8'd0, 8'd65));
    run_sequence(make_req(REQ_CHAR, 8'h81, 8'h7E, 8'd100, 8'd100, 8'd0, 8'd0, 8'd126));
    run_sequence(make_req(REQ_CHAR, 8'h12, 8'h34, 8'd255, 8'd255, 8'd0, 8'd0, 8'd103));
    run_sequence(make_req(REQ_CHAR, 8'hF0, 8'h0F, 8'd10, 8'd20, 8'd0, 8'd0, 8'd31));
    run_sequence(make_req(REQ_CHAR, 8'hF0, 8'h0F, 8'd30, 8'd40, 8'd0, 8'd0, 8'd127));
  endtask

  task automatic test_command_while_busy();
    send_draw_req(make_req(REQ_PIXEL, 8'h11, 8'h22, 8'd40, 8'd41, 8'd0, 8'd0, 8'h00));
    repeat (3) send_draw_req(noise_req(REQ_PULL));
    send_draw_req(noise_req(REQ_FILL));
    send_draw_req(noise_req(REQ_CHAR));
    send_draw_req(noise_req(REQ_PIXEL));
    while (seq_kind != KIND_IDLE) send_draw_req(noise_req(REQ_PULL));
  endtask

  task automatic test_full_width_fill();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_sequence(make_req(REQ_FILL, 8'hE7, 8'h00, 8'd255, 8'd9, 8'd0, 8'd9, 8'h00));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_back_pressure();
    tx_idle_en = 1'b0;
    hold_req   = 1'b1;
    run_sequence(make_req(REQ_CHAR, 8'h0F, 8'hF0, 8'd20, 8'd30, 8'd0, 8'd0, 8'd66));
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_mix();
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      if (seq_kind == KIND_IDLE) begin
        if ($urandom_range(0, 99) < 88) send_draw_req(random_command());
        else send_draw_req(noise_req(REQ_PULL));
      end else if ($urandom_range(0, 99) < 94) begin
        send_draw_req(noise_req(REQ_PULL));
      end else begin
        send_draw_req(noise_req(2'($urandom_range(0, 2))));
      end
    end
    while (seq_kind != KIND_IDLE) send_draw_req(noise_req(REQ_PULL));
  endtask

  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!rx_idle_en) begin
        out_ready_i <= 1'b1;
      end else begin
        hold_left = gap_cycles();
        out_ready_i <= (hold_left == 0);
        if (hold_left > 0) hold_left--;
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    ldcs_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: is_data %0d out_value 0x%02h last_word %0d",
               is_data_o, out_value_o, last_word_o);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (is_data_o !== exp_w.is_data) begin
          $error("is_data: expected %0d, got %0d", exp_w.is_data, is_data_o);
          errors++;
        end
        if (out_value_o !== exp_w.value) begin
          $error("out_value: expected 0x%02h, got 0x%02h", exp_w.value, out_value_o);
          errors++;
        end
        if (last_word_o !== exp_w.last) begin
          $error("last_word: expected %0d, got %0d", exp_w.last, last_word_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("lcd_draw_command_sequencer_tb failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_PULL;
    fore_color_i = '0;
    back_color_i = '0;
    x_first_i    = '0;
    y_first_i    = '0;
    x_second_i   = '0;
    y_second_i   = '0;
    char_code_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_pull();
    test_fill_rect();
    test_put_pixel();
    test_draw_char();
    test_command_while_busy();
    test_full_width_fill();
    test_back_pressure();
    test_random_mix();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_words.size() != 0; i++) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      errors++;
    end
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("lcd_draw_command_sequencer_tb passed");
    end else begin
      $display("lcd_draw_command_sequencer_tb failed");
    end
    $finish;
  end

endmodule
